// File: hw/rtl/snls_pkg.sv
package snls_pkg;

   // fixed sizes
   localparam int MAX_STRIDES      = 27;
   localparam int NUM_STRIDES_DEF  = 27;
   localparam int GROUP_SIZE_DEF   = 32;
   localparam int BASE_WIDTH       = 64;
   localparam int OFFSET_WIDTH     = 32;
   localparam int CUTOFF_WIDTH     = 8;
   localparam int CD_WIDTH         = 10;
   localparam int WEIGHT_WIDTH     = 4;
   localparam int HIT_BIT          = 7;

   // residue of the start value: fold bytes, reciprocal quotient, remainder
   localparam int BYTE_BITS        = 8;
   localparam int NUM_BYTES        = BASE_WIDTH / BYTE_BITS;
   localparam int FOLD_WIDTH       = 21;
   localparam int RECIP_SHIFT      = 32;
   localparam int LOAD_STEPS       = 3;
   localparam int STEP_CNT_WIDTH   = $clog2(LOAD_STEPS);

   localparam logic [STEP_CNT_WIDTH-1:0] STEP_FOLD   = 2'd0;
   localparam logic [STEP_CNT_WIDTH-1:0] STEP_DIVIDE = 2'd1;
   localparam logic [STEP_CNT_WIDTH-1:0] STEP_FINISH = 2'd2;

   localparam logic [CUTOFF_WIDTH-1:0] CUTOFF_RESET = 8'd64;

   // prime-power strides and their log weights
   localparam logic [CD_WIDTH-1:0] STRIDE_LEN [MAX_STRIDES] = '{
      10'd8,   10'd64,  10'd512, 10'd9,   10'd81,  10'd729, 10'd5,   10'd25,  10'd125,
      10'd625, 10'd7,   10'd49,  10'd343, 10'd11,  10'd121, 10'd13,  10'd169, 10'd17,
      10'd289, 10'd19,  10'd361, 10'd23,  10'd529, 10'd29,  10'd841, 10'd31,  10'd961
   };

   localparam logic [WEIGHT_WIDTH-1:0] STRIDE_WEIGHT [MAX_STRIDES] = '{
      4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd5, 4'd5, 4'd5,
      4'd5, 4'd6, 4'd6, 4'd6, 4'd8, 4'd8, 4'd8, 4'd8, 4'd9,
      4'd9, 4'd9, 4'd9, 4'd10, 4'd10, 4'd11, 4'd11, 4'd11, 4'd11
   };

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                operation;
      logic [BASE_WIDTH-1:0] base_value;
   } req_type;

   typedef struct packed {
      logic [OFFSET_WIDTH-1:0] position_offset;
      logic                    is_hit;
      logic                    first_in_group;
   } rsp_type;

   // control from the top level to every stride lane
   typedef struct packed {
      logic fold;
      logic divide;
      logic finish;
      logic advance;
   } lane_ctrl_type;

endpackage

// File: hw/rtl/snls_lane.sv
module snls_lane #(
   parameter int STRIDE = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  snls_pkg::lane_ctrl_type           ctrl,
   input  logic [snls_pkg::BASE_WIDTH-1:0]   base,
   output logic                              hit
);
   import snls_pkg::*;

   localparam logic [CD_WIDTH-1:0] STRIDE_CD = CD_WIDTH'(STRIDE);
   localparam int PROD_WIDTH = FOLD_WIDTH + RECIP_SHIFT;
   // ceil(2^32 / stride): exact quotient for every folded value
   localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'(
      ((64'd1 << RECIP_SHIFT) + 64'(STRIDE) - 64'd1) / 64'(STRIDE));

   // 2^(8*idx) mod stride, evaluated at elaboration
   function automatic int byte_weight(input int idx);
      int w;
      w = 1;
      for (int k = 0; k < idx; k++) begin
         w = (w * (1 << BYTE_BITS)) % STRIDE;
      end
      return w;
   endfunction

   logic [CD_WIDTH-1:0]   countdown_ff;
   logic [CD_WIDTH-1:0]   countdown_in;
   logic [FOLD_WIDTH-1:0] fold_ff;
   logic [FOLD_WIDTH-1:0] fold_in;
   logic [FOLD_WIDTH-1:0] quot_ff;
   logic [FOLD_WIDTH-1:0] quot_in;
   logic [FOLD_WIDTH-1:0] fold_term [NUM_BYTES];
   logic [FOLD_WIDTH-1:0] fold_sum;
   logic [PROD_WIDTH-1:0] recip_prod;
   logic [FOLD_WIDTH-1:0] quot_times_stride;
   logic [CD_WIDTH-1:0]   residue;

   // each base byte weighted by its power of 256 modulo the stride
   for (genvar j = 0; j < NUM_BYTES; j++) begin : g_fold
      localparam logic [CD_WIDTH-1:0] BYTE_WT = CD_WIDTH'(byte_weight(j));
      assign fold_term[j] = FOLD_WIDTH'(base[j*BYTE_BITS +: BYTE_BITS]) *
                            FOLD_WIDTH'(BYTE_WT);
   end

   always_comb begin
      fold_sum = '0;
      for (int j = 0; j < NUM_BYTES; j++) begin
         fold_sum = fold_sum + fold_term[j];
      end
   end

   // quotient of the folded value by reciprocal multiplication
   assign recip_prod = PROD_WIDTH'(fold_ff) * PROD_WIDTH'(RECIP);

   // remainder of the folded value, which is the residue of the base
   assign quot_times_stride = quot_ff * FOLD_WIDTH'(STRIDE);
   assign residue           = CD_WIDTH'(fold_ff - quot_times_stride);

   assign fold_in = ctrl.fold ? fold_sum : fold_ff;
   assign quot_in = ctrl.divide ? recip_prod[PROD_WIDTH-1:RECIP_SHIFT] : quot_ff;
   assign hit     = (countdown_ff == '0);

   always_comb begin
      countdown_in = countdown_ff;
      if (ctrl.finish) begin
         // distance to the next multiple of the stride
         countdown_in = (residue == '0) ? '0 : STRIDE_CD - residue;
      end else if (ctrl.advance) begin
         countdown_in = hit ? STRIDE_CD - CD_WIDTH'(1) : countdown_ff - CD_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= '0;
      end else begin
         countdown_ff <= countdown_in;
      end
   end

   always_ff @(posedge clock) begin
      fold_ff <= fold_in;
      quot_ff <= quot_in;
   end

   // countdown never reaches the stride itself
   assert property (@(posedge clock) disable iff (reset)
      countdown_ff < STRIDE_CD)
      else $error("countdown out of range");

endmodule

// File: hw/rtl/smooth_number_log_sieve_core.sv
//  channel   ports                           direction  carries
//  request   req_valid/req_ready/req_payload in         operation, base_value
//  response  rsp_valid/rsp_ready/rsp_payload out        position_offset, is_hit, first_in_group
//  csr       csr_valid/csr_ready/csr_wdata   in         sieve_cutoff
//
//  an advance request yields its response in the cycle after acceptance;
//  advances are accepted back to back while the response register drains
//  a load yields no response and blocks the request channel after acceptance while
//  each stride lane folds the base bytes, takes a reciprocal quotient, then the remainder
//  synchronous active-high reset clears countdowns, position, group flag and cutoff to 64
//  a full response register that is not taken holds back only further requests
module smooth_number_log_sieve_core #(
   parameter int NUM_STRIDES = snls_pkg::NUM_STRIDES_DEF,
   parameter int GROUP_SIZE  = snls_pkg::GROUP_SIZE_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  snls_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output snls_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [snls_pkg::CUTOFF_WIDTH-1:0]     csr_wdata
);
   import snls_pkg::*;

   localparam int GRP_WIDTH = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
   localparam logic [GRP_WIDTH-1:0] GRP_LAST = GRP_WIDTH'(GROUP_SIZE - 1);

   logic [CUTOFF_WIDTH-1:0]   cutoff_ff;
   logic [CUTOFF_WIDTH-1:0]   cutoff_in;
   logic                      loading_ff;
   logic                      loading_in;
   logic [STEP_CNT_WIDTH-1:0] step_cnt_ff;
   logic [STEP_CNT_WIDTH-1:0] step_cnt_in;
   logic [BASE_WIDTH-1:0]     base_ff;
   logic [BASE_WIDTH-1:0]     base_in;
   logic [OFFSET_WIDTH-1:0]   pos_ff;
   logic [OFFSET_WIDTH-1:0]   pos_in;
   logic [GRP_WIDTH-1:0]      grp_ff;
   logic [GRP_WIDTH-1:0]      grp_in;
   logic                      seen_ff;
   logic                      seen_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;

   logic                      req_fire;
   logic                      load_fire;
   logic                      adv_fire;
   lane_ctrl_type             lane_ctrl;
   logic [NUM_STRIDES-1:0]    lane_hit;
   logic [CUTOFF_WIDTH-1:0]   weight_sum;
   logic [CUTOFF_WIDTH-1:0]   log_value;
   logic                      hit;
   logic                      seen_base;

   // handshakes
   assign req_ready = !loading_ff && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign load_fire = req_fire && (req_payload.operation == OP_LOAD);
   assign adv_fire  = req_fire && (req_payload.operation == OP_ADVANCE);
   assign csr_ready = 1'b1;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // lane control
   always_comb begin
      lane_ctrl.fold    = loading_ff && (step_cnt_ff == STEP_FOLD);
      lane_ctrl.divide  = loading_ff && (step_cnt_ff == STEP_DIVIDE);
      lane_ctrl.finish  = loading_ff && (step_cnt_ff == STEP_FINISH);
      lane_ctrl.advance = adv_fire;
   end

   // one lane per stride
   for (genvar i = 0; i < NUM_STRIDES; i++) begin : g_lane
      snls_lane #(
         .STRIDE (int'(STRIDE_LEN[i]))
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .ctrl  (lane_ctrl),
         .base  (base_ff),
         .hit   (lane_hit[i])
      );
   end

   // sum of log weights of the strides that divide this position
   always_comb begin
      weight_sum = '0;
      for (int i = 0; i < NUM_STRIDES; i++) begin
         if (lane_hit[i]) begin
            weight_sum = weight_sum + CUTOFF_WIDTH'(STRIDE_WEIGHT[i]);
         end
      end
   end

   assign log_value = cutoff_ff - weight_sum;
   assign hit       = log_value[HIT_BIT];
   assign seen_base = (grp_ff == '0) ? 1'b0 : seen_ff;

   // load sequencer
   always_comb begin
      loading_in  = loading_ff;
      step_cnt_in = step_cnt_ff;
      base_in     = base_ff;
      if (load_fire) begin
         loading_in  = 1'b1;
         step_cnt_in = STEP_FOLD;
         base_in     = req_payload.base_value;
      end else if (loading_ff) begin
         step_cnt_in = step_cnt_ff + STEP_CNT_WIDTH'(1);
         if (step_cnt_ff == STEP_FINISH) begin
            loading_in = 1'b0;
         end
      end
   end

   // position, group and response
   always_comb begin
      pos_in       = pos_ff;
      grp_in       = grp_ff;
      seen_in      = seen_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load_fire) begin
         pos_in  = '0;
         grp_in  = '0;
         seen_in = 1'b0;
      end else if (adv_fire) begin
         pos_in  = pos_ff + OFFSET_WIDTH'(1);
         // a wrap of the position restarts the group count as well
         grp_in  = ((grp_ff == GRP_LAST) || (pos_ff == '1)) ? '0 : grp_ff + GRP_WIDTH'(1);
         seen_in = seen_base || hit;
         rsp_in.position_offset = pos_ff;
         rsp_in.is_hit          = hit;
         rsp_in.first_in_group  = hit && !seen_base;
         rsp_valid_in           = 1'b1;
      end
   end

   // cutoff register
   assign cutoff_in = (csr_valid && csr_ready) ? csr_wdata : cutoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff    <= CUTOFF_RESET;
         loading_ff   <= 1'b0;
         step_cnt_ff  <= '0;
         pos_ff       <= '0;
         grp_ff       <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cutoff_ff    <= cutoff_in;
         loading_ff   <= loading_in;
         step_cnt_ff  <= step_cnt_in;
         pos_ff       <= pos_in;
         grp_ff       <= grp_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      rsp_ff  <= rsp_in;
   end

   // no request is taken while a load is being reduced
   assert property (@(posedge clock) disable iff (reset)
      loading_ff |-> !req_ready)
      else $error("request accepted during load");

   assert property (@(posedge clock) disable iff (reset)
      load_fire |=> loading_ff && (step_cnt_ff == STEP_FOLD))
      else $error("load did not start the sequencer");

   // a response appears only after an advance request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(adv_fire))
      else $error("response without advance");

   assert property (@(posedge clock) disable iff (reset)
      adv_fire |=> rsp_valid_ff && (rsp_ff.position_offset == $past(pos_ff)))
      else $error("response offset mismatch");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.first_in_group || rsp_ff.is_hit))
      else $error("first in group without hit");

endmodule
